/* hw/rtl/lcs_pkg.sv */
package lcs_pkg;

  localparam int unsigned SYM_W = 8;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned OUT_W = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR   = 2'd0,
    MODE_APPEND1 = 2'd1,
    MODE_APPEND2 = 2'd2,
    MODE_COMPUTE = 2'd3
  } lcs_mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW,
    S_RD,
    S_CMP,
    S_DONE
  } lcs_state_e;

  // string store update request
  typedef struct packed {
    logic clear;
    logic app_first;
    logic app_second;
  } lcs_load_t;

  // string store read enables
  typedef struct packed {
    logic first_re;
    logic second_re;
  } lcs_rd_t;

endpackage

/* hw/rtl/lcs_in_if.sv */
interface lcs_in_if;
  import lcs_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [SYM_W-1:0]  symbol;

  modport source (output valid, output mode, output symbol, input ready);
  modport sink (input valid, input mode, input symbol, output ready);
endinterface

/* hw/rtl/lcs_out_if.sv */
interface lcs_out_if;
  import lcs_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] match_length;
  logic [OUT_W-1:0] end_in_first;
  logic [OUT_W-1:0] end_in_second;
  logic             overflowed;

  modport source (output valid, output match_length, output end_in_first,
                  output end_in_second, output overflowed, input ready);
  modport sink (input valid, input match_length, input end_in_first,
                input end_in_second, input overflowed, output ready);
endinterface

/* hw/rtl/lcs_store.sv */
module lcs_store
  import lcs_pkg::*;
#(
  parameter int unsigned MAX_LEN = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lcs_load_t                          load_i,
  input  logic [SYM_W-1:0]                   symbol_i,
  input  lcs_rd_t                            rd_en_i,
  input  logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] first_addr_i,
  input  logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] second_addr_i,
  output logic [SYM_W-1:0]                   first_data_o,
  output logic [SYM_W-1:0]                   second_data_o,
  output logic [$clog2(MAX_LEN+1)-1:0]       first_len_o,
  output logic [$clog2(MAX_LEN+1)-1:0]       second_len_o,
  output logic                               overflow_o
);

  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [SYM_W-1:0] first_mem [MAX_LEN];
  logic [SYM_W-1:0] second_mem [MAX_LEN];
  logic [SYM_W-1:0] first_data_q, second_data_q;
  logic [LW-1:0]    first_len_q, first_len_d;
  logic [LW-1:0]    second_len_q, second_len_d;
  logic             overflow_q, overflow_d;
  logic             first_full, second_full;

  assign first_full  = (first_len_q == LW'(MAX_LEN));
  assign second_full = (second_len_q == LW'(MAX_LEN));

  always_ff @(posedge clk_i) begin
    if (load_i.app_first && !first_full) begin
      first_mem[first_len_q[AW-1:0]] <= symbol_i;
    end
    if (load_i.app_second && !second_full) begin
      second_mem[second_len_q[AW-1:0]] <= symbol_i;
    end
    if (rd_en_i.first_re) begin
      first_data_q <= first_mem[first_addr_i];
    end
    if (rd_en_i.second_re) begin
      second_data_q <= second_mem[second_addr_i];
    end
  end

  always_comb begin
    first_len_d  = first_len_q;
    second_len_d = second_len_q;
    overflow_d   = overflow_q;
    if (load_i.clear) begin
      first_len_d  = '0;
      second_len_d = '0;
      overflow_d   = 1'b0;
    end else if (load_i.app_first) begin
      if (first_full) begin
        overflow_d = 1'b1;
      end else begin
        first_len_d = first_len_q + LW'(1);
      end
    end else if (load_i.app_second) begin
      if (second_full) begin
        overflow_d = 1'b1;
      end else begin
        second_len_d = second_len_q + LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_len_q  <= '0;
      second_len_q <= '0;
      overflow_q   <= 1'b0;
    end else begin
      first_len_q  <= first_len_d;
      second_len_q <= second_len_d;
      overflow_q   <= overflow_d;
    end
  end

  assign first_data_o  = first_data_q;
  assign second_data_o = second_data_q;
  assign first_len_o   = first_len_q;
  assign second_len_o  = second_len_q;
  assign overflow_o    = overflow_q;

endmodule

/* hw/rtl/lcs_core.sv */
module lcs_core
  import lcs_pkg::*;
#(
  parameter int unsigned MAX_LEN = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               in_ready_o,
  input  logic [$clog2(MAX_LEN+1)-1:0]       first_len_i,
  input  logic [$clog2(MAX_LEN+1)-1:0]       second_len_i,
  input  logic                               overflow_i,
  output lcs_rd_t                            rd_en_o,
  output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] first_addr_o,
  output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] second_addr_o,
  input  logic [SYM_W-1:0]                   first_data_i,
  input  logic [SYM_W-1:0]                   second_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [OUT_W-1:0]                   match_length_o,
  output logic [OUT_W-1:0]                   end_in_first_o,
  output logic [OUT_W-1:0]                   end_in_second_o,
  output logic                               overflowed_o
);

  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  lcs_state_e state_q, state_d;

  logic [LW-1:0] i_q, i_d, j_q, j_d;
  logic [LW-1:0] diag_q, diag_d;
  logic [LW-1:0] best_len_q, best_len_d;
  logic [LW-1:0] best_i_q, best_i_d;
  logic [LW-1:0] best_j_q, best_j_d;
  logic          out_valid_q, out_valid_d;
  logic [OUT_W-1:0] len_out_q, len_out_d;
  logic [OUT_W-1:0] ei_out_q, ei_out_d;
  logic [OUT_W-1:0] ej_out_q, ej_out_d;
  logic          ovf_out_q, ovf_out_d;

  // one previous-row entry per column, updated in place
  logic [LW-1:0] row_mem [MAX_LEN+1];
  logic [LW-1:0] row_rdata_q;
  logic          row_re, row_we;
  logic [LW-1:0] cur_val;

  logic [LW-1:0] im1, jm1, prev_val, cand;
  logic          hit;
  logic [LW+OUT_W-1:0] len_ext, ei_ext, ej_ext;

  assign im1 = i_q - LW'(1);
  assign jm1 = j_q - LW'(1);
  assign first_addr_o  = im1[AW-1:0];
  assign second_addr_o = jm1[AW-1:0];

  // row 1 sees an all-zero previous row, so the scratch row needs no clearing
  assign prev_val = (i_q == LW'(1)) ? '0 : row_rdata_q;
  assign hit      = (first_data_i == second_data_i);
  assign cand     = diag_q + LW'(1);
  assign cur_val  = hit ? cand : '0;

  assign len_ext = {{OUT_W{1'b0}}, best_len_q};
  assign ei_ext  = {{OUT_W{1'b0}}, best_i_q};
  assign ej_ext  = {{OUT_W{1'b0}}, best_j_q};

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[j_q] <= cur_val;
    end
    if (row_re) begin
      row_rdata_q <= row_mem[j_q];
    end
  end

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    diag_d      = diag_q;
    best_len_d  = best_len_q;
    best_i_d    = best_i_q;
    best_j_d    = best_j_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    len_out_d   = len_out_q;
    ei_out_d    = ei_out_q;
    ej_out_d    = ej_out_q;
    ovf_out_d   = ovf_out_q;
    rd_en_o     = '0;
    row_re      = 1'b0;
    row_we      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          best_len_d = '0;
          best_i_d   = '0;
          best_j_d   = '0;
          i_d        = LW'(1);
          j_d        = LW'(1);
          if (first_len_i == '0 || second_len_i == '0) begin
            state_d = S_DONE;
          end else begin
            state_d = S_ROW;
          end
        end
      end
      S_ROW: begin
        rd_en_o.first_re = 1'b1;
        diag_d  = '0;
        state_d = S_RD;
      end
      S_RD: begin
        rd_en_o.second_re = 1'b1;
        row_re  = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        row_we = 1'b1;
        diag_d = prev_val;
        // >= keeps the last maximum in row-major order
        if (hit && cand >= best_len_q) begin
          best_len_d = cand;
          best_i_d   = i_q;
          best_j_d   = j_q;
        end
        if (j_q == second_len_i) begin
          j_d = LW'(1);
          if (i_q == first_len_i) begin
            state_d = S_DONE;
          end else begin
            i_d     = i_q + LW'(1);
            state_d = S_ROW;
          end
        end else begin
          j_d     = j_q + LW'(1);
          state_d = S_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          len_out_d   = len_ext[OUT_W-1:0];
          ei_out_d    = ei_ext[OUT_W-1:0];
          ej_out_d    = ej_ext[OUT_W-1:0];
          ovf_out_d   = overflow_i;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    j_q        <= j_d;
    diag_q     <= diag_d;
    best_len_q <= best_len_d;
    best_i_q   <= best_i_d;
    best_j_q   <= best_j_d;
    len_out_q  <= len_out_d;
    ei_out_q   <= ei_out_d;
    ej_out_q   <= ej_out_d;
    ovf_out_q  <= ovf_out_d;
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign match_length_o  = len_out_q;
  assign end_in_first_o  = ei_out_q;
  assign end_in_second_o = ej_out_q;
  assign overflowed_o    = ovf_out_q;

`ifndef ASSERT_OFF
  a_cell_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |-> (j_q != '0 && j_q <= second_len_i &&
                          i_q != '0 && i_q <= first_len_i))
    else $error("table cell index outside the loaded strings");

  a_best_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> (best_len_q <= i_q && best_len_q <= second_len_i))
    else $error("best match longer than the rows walked");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the done step");
`endif

endmodule

/* hw/rtl/longest_common_substring_top.sv */
// Longest common substring of two byte strings of up to MAX_LEN characters.
// Each item carries a mode: clear both strings, append the symbol to the
// first or second string, or compute. Clear and append return nothing;
// an append to a full string is dropped and sets the overflow flag, which
// clear resets. Compute returns one item with the match length and the
// one-past-end positions in both strings (ties go to the last maximum in
// row-major order; all zero when nothing matches). A compute keeps the
// block busy after acceptance: one byte comparator and one increment are
// shared across the table cells, each row first fetches its first-string
// character, each cell then does the registered reads of its second-string
// character and row-memory entry before the compare, and the result is
// then handed over. A finished result waits in an output register while
// loads continue; a compute that finishes while that register still holds
// an unaccepted result stays busy until the older one is taken.
module longest_common_substring_top
  import lcs_pkg::*;
#(
  parameter int unsigned MAX_LEN = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  lcs_in_if.sink    in_i,
  lcs_out_if.source out_o
);

  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic          in_ready, accept;
  lcs_load_t     load;
  lcs_rd_t       rd_en;
  logic [AW-1:0] first_addr, second_addr;
  logic [SYM_W-1:0] first_data, second_data;
  logic [LW-1:0] first_len, second_len;
  logic          overflow;
  logic          start;

  assign accept     = in_i.valid & in_ready;
  assign in_i.ready = in_ready;

  assign load.clear      = accept && (in_i.mode == MODE_CLEAR);
  assign load.app_first  = accept && (in_i.mode == MODE_APPEND1);
  assign load.app_second = accept && (in_i.mode == MODE_APPEND2);
  assign start           = accept && (in_i.mode == MODE_COMPUTE);

  lcs_store #(
    .MAX_LEN (MAX_LEN)
  ) u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .symbol_i      (in_i.symbol),
    .rd_en_i       (rd_en),
    .first_addr_i  (first_addr),
    .second_addr_i (second_addr),
    .first_data_o  (first_data),
    .second_data_o (second_data),
    .first_len_o   (first_len),
    .second_len_o  (second_len),
    .overflow_o    (overflow)
  );

  lcs_core #(
    .MAX_LEN (MAX_LEN)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .in_ready_o      (in_ready),
    .first_len_i     (first_len),
    .second_len_i    (second_len),
    .overflow_i      (overflow),
    .rd_en_o         (rd_en),
    .first_addr_o    (first_addr),
    .second_addr_o   (second_addr),
    .first_data_i    (first_data),
    .second_data_i   (second_data),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .match_length_o  (out_o.match_length),
    .end_in_first_o  (out_o.end_in_first),
    .end_in_second_o (out_o.end_in_second),
    .overflowed_o    (out_o.overflowed)
  );

endmodule
